FILE: design/cbl_pkg.sv
// ----------------------------------------------------------------------------
// cbl_pkg
// Shared types and constants of the backbone chain break labeler.
// ----------------------------------------------------------------------------
package cbl_pkg;

  localparam int DEFAULT_MAX_LABELS = 16;

  localparam int COORD_W    = 25;
  localparam int MAG_W      = 25;
  localparam int SQ_W       = 50;
  localparam int SUM_W      = 52;
  localparam int LIMIT_W    = 40;
  localparam int CNT_W      = 5;
  localparam int LABEL_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [LIMIT_W-1:0] CN_LIMIT_RESET = 40'd3500000;
  localparam logic [LIMIT_W-1:0] CA_LIMIT_RESET = 40'd16000000;
  localparam logic [LABEL_W-1:0] ASCII_A        = 8'd65;
  localparam logic [CNT_W-1:0]   ALPHABET_LAST  = 5'd25;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CN_LIMIT   = 3'd0,
    CFG_CA_LIMIT   = 3'd1,
    CFG_BUMP_HET   = 3'd2,
    CFG_LABEL_CNT  = 3'd3,
    CFG_LABELS_LO  = 3'd4,
    CFG_LABELS_HI  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_CN    = 2'd1,
    MODE_CA    = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } pos_t;

  typedef struct packed {
    mode_e mode;
    pos_t  a;
    pos_t  b;
    logic  het_brk;
    logic  missing;
  } sel_t;

  typedef struct packed {
    mode_e           mode;
    logic [SQ_W-1:0] sq_x;
    logic [SQ_W-1:0] sq_y;
    logic [SQ_W-1:0] sq_z;
    logic            het_brk;
    logic            missing;
  } sq_t;

endpackage

FILE: design/cbl_if.sv
// ----------------------------------------------------------------------------
// cbl_if
// Valid/ready channels carrying residue summaries in and chain labels out.
// ----------------------------------------------------------------------------
interface cbl_in_if;
  logic                  valid;
  logic                  ready;
  logic [2:0]            atom_present;
  cbl_pkg::coord_t       n_x;
  cbl_pkg::coord_t       n_y;
  cbl_pkg::coord_t       n_z;
  cbl_pkg::coord_t       ca_x;
  cbl_pkg::coord_t       ca_y;
  cbl_pkg::coord_t       ca_z;
  cbl_pkg::coord_t       c_x;
  cbl_pkg::coord_t       c_y;
  cbl_pkg::coord_t       c_z;
  logic                  is_hetatm;

  modport source (
    output valid, atom_present, n_x, n_y, n_z, ca_x, ca_y, ca_z, c_x, c_y, c_z,
           is_hetatm,
    input  ready
  );

  modport sink (
    input  valid, atom_present, n_x, n_y, n_z, ca_x, ca_y, ca_z, c_x, c_y, c_z,
           is_hetatm,
    output ready
  );
endinterface

interface cbl_out_if;
  logic                            valid;
  logic                            ready;
  logic [cbl_pkg::LABEL_W-1:0]     chain_label;
  logic                            chain_started;
  logic                            atoms_missing;

  modport source (
    output valid, chain_label, chain_started, atoms_missing,
    input  ready
  );

  modport sink (
    input  valid, chain_label, chain_started, atoms_missing,
    output ready
  );
endinterface

FILE: design/backbone_chain_break_labeler.sv
// ----------------------------------------------------------------------------
// backbone_chain_break_labeler
// Assigns chain labels to a stream of residue backbone summaries.
// ----------------------------------------------------------------------------
// One residue beat is accepted every clock cycle unless the output stalls;
// each beat yields one result beat via the input, squaring and result
// registers. The test pair is chosen against the previous residue when the
// beat is taken, three 25x25 multipliers in the middle stage give the squared
// distance, and the compare and label update close in the last stage. The
// user must write configuration through the plain write port only while the
// stream is idle; the block does not enforce it. Unlisted indexes are ignored.
module backbone_chain_break_labeler #(
  parameter int MAX_LABELS = cbl_pkg::DEFAULT_MAX_LABELS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cbl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cbl_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  cbl_in_if.sink                            in_i,
  cbl_out_if.source                         out_o
);

  logic [cbl_pkg::LIMIT_W-1:0]    cn_limit_q, ca_limit_q;
  logic                           bump_q;
  logic [cbl_pkg::CNT_W-1:0]      label_cnt_q;
  logic [cbl_pkg::CFG_DATA_W-1:0] labels_lo_q, labels_hi_q;

  logic          s1_valid, s1_ready, s2_valid, s2_ready;
  cbl_pkg::sel_t s1;
  cbl_pkg::sq_t  s2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cn_limit_q  <= cbl_pkg::CN_LIMIT_RESET;
      ca_limit_q  <= cbl_pkg::CA_LIMIT_RESET;
      bump_q      <= 1'b0;
      label_cnt_q <= '0;
      labels_lo_q <= '0;
      labels_hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cbl_pkg::CFG_CN_LIMIT:  cn_limit_q  <= cfg_data_i[cbl_pkg::LIMIT_W-1:0];
        cbl_pkg::CFG_CA_LIMIT:  ca_limit_q  <= cfg_data_i[cbl_pkg::LIMIT_W-1:0];
        cbl_pkg::CFG_BUMP_HET:  bump_q      <= cfg_data_i[0];
        cbl_pkg::CFG_LABEL_CNT: label_cnt_q <= cfg_data_i[cbl_pkg::CNT_W-1:0];
        cbl_pkg::CFG_LABELS_LO: labels_lo_q <= cfg_data_i;
        cbl_pkg::CFG_LABELS_HI: labels_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cbl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bump_on_het_i (bump_q),
    .in_i          (in_i),
    .s1_valid_o    (s1_valid),
    .s1_ready_i    (s1_ready),
    .s1_o          (s1)
  );

  cbl_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s1_i       (s1),
    .s2_valid_o (s2_valid),
    .s2_ready_i (s2_ready),
    .s2_o       (s2)
  );

  cbl_label #(
    .MAX_LABELS (MAX_LABELS)
  ) u_label (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cn_limit_sq_i   (cn_limit_q),
    .ca_limit_sq_i   (ca_limit_q),
    .label_count_i   (label_cnt_q),
    .labels_first_i  (labels_lo_q),
    .labels_second_i (labels_hi_q),
    .s2_valid_i      (s2_valid),
    .s2_ready_o      (s2_ready),
    .s2_i            (s2),
    .out_o           (out_o)
  );

endmodule

FILE: design/cbl_front.sv
// ----------------------------------------------------------------------------
// cbl_front
// Input register: keeps the previous residue's atoms and picks the test.
// ----------------------------------------------------------------------------
module cbl_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            bump_on_het_i,
  cbl_in_if.sink          in_i,
  output logic            s1_valid_o,
  input  logic            s1_ready_i,
  output cbl_pkg::sel_t   s1_o
);

  logic          s1_valid_q;
  cbl_pkg::sel_t s1_q, s1_d;

  logic          prev_c_valid_q, prev_ca_valid_q, prev_het_q, seen_q;
  cbl_pkg::pos_t prev_c_q, prev_ca_q;

  logic          accept;
  logic          has_n, has_ca, has_c;
  cbl_pkg::pos_t n_pos, ca_pos, c_pos;

  assign in_i.ready = !s1_valid_q || s1_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  assign has_n  = in_i.atom_present[0];
  assign has_ca = in_i.atom_present[1];
  assign has_c  = in_i.atom_present[2];

  assign n_pos  = '{x: in_i.n_x,  y: in_i.n_y,  z: in_i.n_z};
  assign ca_pos = '{x: in_i.ca_x, y: in_i.ca_y, z: in_i.ca_z};
  assign c_pos  = '{x: in_i.c_x,  y: in_i.c_y,  z: in_i.c_z};

  always_comb begin
    s1_d         = '0;
    s1_d.mode    = cbl_pkg::MODE_FIRST;
    if (!seen_q) begin
      s1_d.mode = cbl_pkg::MODE_FIRST;
    end else if (prev_c_valid_q && has_n) begin
      s1_d.mode = cbl_pkg::MODE_CN;
      s1_d.a    = prev_c_q;
      s1_d.b    = n_pos;
    end else if (prev_ca_valid_q && has_ca) begin
      s1_d.mode = cbl_pkg::MODE_CA;
      s1_d.a    = prev_ca_q;
      s1_d.b    = ca_pos;
    end else begin
      s1_d.mode    = cbl_pkg::MODE_NONE;
      s1_d.missing = !prev_het_q && !in_i.is_hetatm;
      s1_d.het_brk = bump_on_het_i && prev_het_q && !in_i.is_hetatm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q      <= 1'b0;
      prev_c_valid_q  <= 1'b0;
      prev_ca_valid_q <= 1'b0;
      prev_het_q      <= 1'b0;
      seen_q          <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (accept) begin
        prev_c_valid_q  <= has_c;
        prev_ca_valid_q <= has_ca;
        prev_het_q      <= in_i.is_hetatm;
        seen_q          <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q      <= s1_d;
      prev_c_q  <= c_pos;
      prev_ca_q <= ca_pos;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

endmodule

FILE: design/cbl_dist.sv
// ----------------------------------------------------------------------------
// cbl_dist
// Squares the per-axis differences of the selected atom pair.
// ----------------------------------------------------------------------------
module cbl_dist (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s1_valid_i,
  output logic            s1_ready_o,
  input  cbl_pkg::sel_t   s1_i,
  output logic            s2_valid_o,
  input  logic            s2_ready_i,
  output cbl_pkg::sq_t    s2_o
);

  logic         s2_valid_q;
  cbl_pkg::sq_t s2_q, s2_d;
  logic         advance;

  function automatic logic [cbl_pkg::SQ_W-1:0] sq_diff(cbl_pkg::coord_t a,
                                                       cbl_pkg::coord_t b);
    logic signed [cbl_pkg::COORD_W:0] d;
    logic        [cbl_pkg::COORD_W:0] m;
    logic        [cbl_pkg::MAG_W-1:0] mag;
    d   = {a[cbl_pkg::COORD_W-1], a} - {b[cbl_pkg::COORD_W-1], b};
    m   = d[cbl_pkg::COORD_W] ? (~d + 1'b1) : d;
    mag = m[cbl_pkg::MAG_W-1:0];
    return mag * mag;
  endfunction

  assign s1_ready_o = !s2_valid_q || s2_ready_i;
  assign advance    = s1_valid_i && s1_ready_o;

  always_comb begin
    s2_d.mode    = s1_i.mode;
    s2_d.sq_x    = sq_diff(s1_i.a.x, s1_i.b.x);
    s2_d.sq_y    = sq_diff(s1_i.a.y, s1_i.b.y);
    s2_d.sq_z    = sq_diff(s1_i.a.z, s1_i.b.z);
    s2_d.het_brk = s1_i.het_brk;
    s2_d.missing = s1_i.missing;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      s2_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_q <= s2_d;
    end
  end

  assign s2_valid_o = s2_valid_q;
  assign s2_o       = s2_q;

endmodule

FILE: design/cbl_label.sv
// ----------------------------------------------------------------------------
// cbl_label
// Break decision, chain count and label selection, result register.
// ----------------------------------------------------------------------------
module cbl_label #(
  parameter int MAX_LABELS = cbl_pkg::DEFAULT_MAX_LABELS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [cbl_pkg::LIMIT_W-1:0]       cn_limit_sq_i,
  input  logic [cbl_pkg::LIMIT_W-1:0]       ca_limit_sq_i,
  input  logic [cbl_pkg::CNT_W-1:0]         label_count_i,
  input  logic [cbl_pkg::CFG_DATA_W-1:0]    labels_first_i,
  input  logic [cbl_pkg::CFG_DATA_W-1:0]    labels_second_i,
  input  logic                              s2_valid_i,
  output logic                              s2_ready_o,
  input  cbl_pkg::sq_t                      s2_i,
  cbl_out_if.source                         out_o
);

  localparam int IdxW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam logic [cbl_pkg::CNT_W-1:0] MaxCnt = cbl_pkg::CNT_W'(MAX_LABELS);

  logic                          out_valid_q;
  logic [cbl_pkg::LABEL_W-1:0]   label_q, label_d;
  logic                          started_q, started_d;
  logic                          missing_q;
  logic [cbl_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [cbl_pkg::CNT_W-1:0]     idx_q, idx_d;

  logic                          advance;
  logic [2*cbl_pkg::CFG_DATA_W-1:0] label_bytes;
  logic [cbl_pkg::LABEL_W-1:0]   user_lbl [MAX_LABELS];
  logic [cbl_pkg::CNT_W-1:0]     count;
  logic [cbl_pkg::SUM_W-1:0]     sum;
  logic [cbl_pkg::LIMIT_W-1:0]   limit;
  logic                          brk;

  assign s2_ready_o = !out_valid_q || out_o.ready;
  assign advance    = s2_valid_i && s2_ready_o;

  assign label_bytes = {labels_second_i, labels_first_i};

  always_comb begin
    for (int i = 0; i < MAX_LABELS; i++) begin
      user_lbl[i] = label_bytes[cbl_pkg::LABEL_W*i +: cbl_pkg::LABEL_W];
    end
  end

  assign count = (label_count_i > MaxCnt) ? MaxCnt : label_count_i;

  assign sum = cbl_pkg::SUM_W'(s2_i.sq_x) + cbl_pkg::SUM_W'(s2_i.sq_y)
             + cbl_pkg::SUM_W'(s2_i.sq_z);
  assign limit = (s2_i.mode == cbl_pkg::MODE_CN) ? cn_limit_sq_i : ca_limit_sq_i;

  always_comb begin
    unique case (s2_i.mode)
      cbl_pkg::MODE_CN,
      cbl_pkg::MODE_CA:   brk = sum > cbl_pkg::SUM_W'(limit);
      cbl_pkg::MODE_NONE: brk = s2_i.het_brk;
      default:            brk = 1'b0;
    endcase
  end

  always_comb begin
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    label_d   = label_q;
    started_d = 1'b0;
    if (s2_i.mode == cbl_pkg::MODE_FIRST) begin
      cnt_d   = '0;
      idx_d   = '0;
      label_d = (count != '0) ? user_lbl[0] : cbl_pkg::ASCII_A;
    end else if (brk) begin
      started_d = 1'b1;
      cnt_d     = (cnt_q == cbl_pkg::ALPHABET_LAST) ? '0 : cnt_q + 1'b1;
      idx_d     = (idx_q < count) ? idx_q + 1'b1 : idx_q;
      label_d   = (idx_d < count) ? user_lbl[idx_d[IdxW-1:0]]
                                  : cbl_pkg::ASCII_A + cbl_pkg::LABEL_W'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      label_q     <= cbl_pkg::ASCII_A;
    end else begin
      if (s2_ready_o) begin
        out_valid_q <= s2_valid_i;
      end
      if (advance) begin
        cnt_q   <= cnt_d;
        idx_q   <= idx_d;
        label_q <= label_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      started_q <= started_d;
      missing_q <= s2_i.missing;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.chain_label   = label_q;
  assign out_o.chain_started = started_q;
  assign out_o.atoms_missing = missing_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cbl_pkg::ALPHABET_LAST)
    else $error("chain count out of range");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= MaxCnt)
    else $error("label index beyond label list");

  a_first_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s2_i.mode == cbl_pkg::MODE_FIRST |=>
      out_valid_q && !started_q && !missing_q && cnt_q == '0 && idx_q == '0)
    else $error("first residue not a clean chain start");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(started_q && missing_q))
    else $error("break and missing atoms flagged together");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(cnt_q) && $stable(idx_q))
    else $error("chain state moved without a beat");
`endif

endmodule
